@@ hw/rtl/hmaa_pkg.sv @@
// shared types and constants for the hour meter adc averager
// no dependencies; imported by every module of the block
package hmaa_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TICK_W = 8;
    localparam int TENTH_W = 10;
    localparam int HOUR_W = 20;
    localparam int SETTLE_W = 7;
    localparam int VSUM_W = 17;

    localparam int VOLT_SAMPLES = 21;
    localparam int CURR_SHIFT = 3;
    localparam int SETTLE_MAX = 100;

    localparam int VCNT_W = $clog2(VOLT_SAMPLES);
    localparam int CURR_SAMPLES = 1 << CURR_SHIFT;
    localparam int CCNT_W = (CURR_SHIFT > 0) ? CURR_SHIFT : 1;
    localparam int CSUM_W = SAMPLE_W + CURR_SHIFT;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(125);
    localparam logic [TENTH_W-1:0] TENTHS_RESET = TENTH_W'(720);
    localparam logic [HOUR_W-1:0] HOUR_LIMIT_RESET = HOUR_W'(999999);
    localparam logic [SAMPLE_W-1:0] LOW_LEVEL_RESET = SAMPLE_W'(960);
    localparam logic [SETTLE_W-1:0] SETTLE_LIMIT_RESET = SETTLE_W'(60);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_HALF = 3'd0,
        REG_HALF_PER_TENTH = 3'd1,
        REG_HOUR_LIMIT = 3'd2,
        REG_LOW_LEVEL = 3'd3,
        REG_SETTLE_LIMIT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] ticks_per_half_second;
        logic [TENTH_W-1:0] half_seconds_per_tenth;
        logic [HOUR_W-1:0] hour_limit;
        logic [SAMPLE_W-1:0] low_voltage_level;
        logic [SETTLE_W-1:0] settle_limit;
    } cfg_t;

    typedef struct packed {
        logic half_pulse;
        logic blink;
        logic [TENTH_W-1:0] tenth;
        logic [HOUR_W-1:0] hour;
    } tb_stat_t;

    typedef struct packed {
        logic [VSUM_W-1:0] voltage_total;
        logic [SAMPLE_W-1:0] current_average;
        logic power_off;
        logic was_voltage;
    } adc_stat_t;

endpackage

@@ hw/rtl/hmaa_timebase.sv @@
// half-second tick counter, blink, tenth-hour and hour counters, settle counter
// depends on hmaa_pkg
module hmaa_timebase
    import hmaa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cfg_t                cfg,
    output tb_stat_t            stat,
    output logic [SETTLE_W-1:0] settle_now
);

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic blink_reg, blink_next;
    logic [TENTH_W-1:0] tenth_reg, tenth_next;
    logic [HOUR_W-1:0] hour_reg, hour_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;

    logic [TICK_W:0] tick_inc;
    logic [TENTH_W:0] tenth_inc;
    logic half_event;
    logic tenth_wrap;

    always_comb
    begin
        tick_inc = {1'b0, tick_reg} + 1'b1;
        half_event = (tick_inc >= {1'b0, cfg.ticks_per_half_second});
        tick_next = half_event ? '0 : tick_inc[TICK_W-1:0];
        blink_next = blink_reg ^ half_event;

        tenth_inc = {1'b0, tenth_reg} + 1'b1;
        tenth_wrap = (tenth_inc >= {1'b0, cfg.half_seconds_per_tenth});
        tenth_next = tenth_reg;
        hour_next = hour_reg;
        if (half_event)
        begin
            if (tenth_wrap)
            begin
                tenth_next = '0;
                // wrap to zero once the limit is reached
                hour_next = (hour_reg < cfg.hour_limit) ? hour_reg + 1'b1 : '0;
            end
            else
            begin
                tenth_next = tenth_inc[TENTH_W-1:0];
            end
        end

        settle_next = settle_reg;
        if (half_event && (settle_reg < SETTLE_W'(SETTLE_MAX)))
        begin
            settle_next = settle_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            blink_reg <= 1'b0;
            tenth_reg <= '0;
            hour_reg <= '0;
            settle_reg <= '0;
        end
        else if (step)
        begin
            tick_reg <= tick_next;
            blink_reg <= blink_next;
            tenth_reg <= tenth_next;
            hour_reg <= hour_next;
            settle_reg <= settle_next;
        end
    end

    assign stat.half_pulse = half_event;
    assign stat.blink = blink_next;
    assign stat.tenth = tenth_next;
    assign stat.hour = hour_next;
    assign settle_now = settle_reg;

endmodule

@@ hw/rtl/hmaa_adc.sv @@
// channel alternation, voltage block sum, current block mean, power-off flag
// depends on hmaa_pkg
module hmaa_adc
    import hmaa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [SAMPLE_W-1:0] sample,
    input  cfg_t                cfg,
    input  logic [SETTLE_W-1:0] settle_now,
    output adc_stat_t           stat
);

    logic phase_reg;
    logic [VSUM_W-1:0] vsum_reg, vsum_next;
    logic [VCNT_W-1:0] vcnt_reg, vcnt_next;
    logic [VSUM_W-1:0] vres_reg, vres_next;
    logic [CSUM_W-1:0] csum_reg, csum_next;
    logic [CCNT_W-1:0] ccnt_reg, ccnt_next;
    logic [SAMPLE_W-1:0] cres_reg, cres_next;
    logic poff_reg, poff_next;

    logic [VSUM_W-1:0] vsum_add;
    logic [CSUM_W-1:0] csum_add;
    logic [VCNT_W:0] vcnt_inc;
    logic [CCNT_W:0] ccnt_inc;

    always_comb
    begin
        vsum_add = vsum_reg + VSUM_W'(sample);
        csum_add = csum_reg + CSUM_W'(sample);
        vcnt_inc = {1'b0, vcnt_reg} + 1'b1;
        ccnt_inc = {1'b0, ccnt_reg} + 1'b1;

        vsum_next = vsum_reg;
        vcnt_next = vcnt_reg;
        vres_next = vres_reg;
        csum_next = csum_reg;
        ccnt_next = ccnt_reg;
        cres_next = cres_reg;
        poff_next = poff_reg;

        if (phase_reg)
        begin
            // voltage word
            if (sample < cfg.low_voltage_level)
            begin
                poff_next = (settle_now > cfg.settle_limit);
            end
            if (vcnt_inc >= (VCNT_W + 1)'(VOLT_SAMPLES))
            begin
                vres_next = vsum_add;
                vsum_next = '0;
                vcnt_next = '0;
            end
            else
            begin
                vsum_next = vsum_add;
                vcnt_next = vcnt_inc[VCNT_W-1:0];
            end
        end
        else
        begin
            // current word
            if (ccnt_inc >= (CCNT_W + 1)'(CURR_SAMPLES))
            begin
                cres_next = SAMPLE_W'(csum_add >> CURR_SHIFT);
                csum_next = '0;
                ccnt_next = '0;
            end
            else
            begin
                csum_next = csum_add;
                ccnt_next = ccnt_inc[CCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            vsum_reg <= '0;
            vcnt_reg <= '0;
            vres_reg <= '0;
            csum_reg <= '0;
            ccnt_reg <= '0;
            cres_reg <= '0;
            poff_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= ~phase_reg;
            vsum_reg <= vsum_next;
            vcnt_reg <= vcnt_next;
            vres_reg <= vres_next;
            csum_reg <= csum_next;
            ccnt_reg <= ccnt_next;
            cres_reg <= cres_next;
            poff_reg <= poff_next;
        end
    end

    assign stat.voltage_total = vres_next;
    assign stat.current_average = cres_next;
    assign stat.power_off = poff_next;
    assign stat.was_voltage = phase_reg;

endmodule

@@ hw/rtl/hour_meter_adc_averager.sv @@
// hour meter with adc averaging: input register, update logic, result register
// accepted words pass input then result register; throughput 1 word per cycle
// with out_ready high, back pressure stalls the input register and then in_ready
// all counters, averagers, flags and handshake state clear on rst_n low (async);
// configuration registers return to their default values
// depends on hmaa_pkg, hmaa_timebase, hmaa_adc
module hour_meter_adc_averager
    import hmaa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  half_second_pulse,
    output logic                  blink,
    output logic [TENTH_W-1:0]    tenth_progress,
    output logic [HOUR_W-1:0]     hour_tenths,
    output logic [VSUM_W-1:0]     voltage_total,
    output logic [SAMPLE_W-1:0]   current_average,
    output logic                  power_off,
    output logic                  sample_was_voltage
);

    cfg_t cfg_reg;
    logic in_vld_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic out_vld_reg;
    tb_stat_t tb_res_reg;
    adc_stat_t adc_res_reg;

    tb_stat_t tb_stat;
    adc_stat_t adc_stat;
    logic [SETTLE_W-1:0] settle_now;
    logic advance;

    assign advance = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_half_second <= TICKS_RESET;
            cfg_reg.half_seconds_per_tenth <= TENTHS_RESET;
            cfg_reg.hour_limit <= HOUR_LIMIT_RESET;
            cfg_reg.low_voltage_level <= LOW_LEVEL_RESET;
            cfg_reg.settle_limit <= SETTLE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TICKS_PER_HALF: cfg_reg.ticks_per_half_second <= cfg_data[TICK_W-1:0];
                REG_HALF_PER_TENTH: cfg_reg.half_seconds_per_tenth <= cfg_data[TENTH_W-1:0];
                REG_HOUR_LIMIT:     cfg_reg.hour_limit <= cfg_data[HOUR_W-1:0];
                REG_LOW_LEVEL:      cfg_reg.low_voltage_level <= cfg_data[SAMPLE_W-1:0];
                REG_SETTLE_LIMIT:   cfg_reg.settle_limit <= cfg_data[SETTLE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= adc_sample;
        end
        if (advance)
        begin
            tb_res_reg <= tb_stat;
            adc_res_reg <= adc_stat;
        end
    end

    hmaa_timebase u_timebase (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .cfg        (cfg_reg),
        .stat       (tb_stat),
        .settle_now (settle_now)
    );

    hmaa_adc u_adc (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .sample     (sample_reg),
        .cfg        (cfg_reg),
        .settle_now (settle_now),
        .stat       (adc_stat)
    );

    assign out_valid = out_vld_reg;
    assign half_second_pulse = tb_res_reg.half_pulse;
    assign blink = tb_res_reg.blink;
    assign tenth_progress = tb_res_reg.tenth;
    assign hour_tenths = tb_res_reg.hour;
    assign voltage_total = adc_res_reg.voltage_total;
    assign current_average = adc_res_reg.current_average;
    assign power_off = adc_res_reg.power_off;
    assign sample_was_voltage = adc_res_reg.was_voltage;

endmodule

@@ tb/hmaa_meter_checker.sv @@
`timescale 1ns / 1ps
// checker for the hour meter adc averager: follows register writes and accepted
// samples, predicts every output word and compares it on acceptance
// depends on hmaa_pkg
module hmaa_meter_checker
    import hmaa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  half_second_pulse,
    input  logic                  blink,
    input  logic [TENTH_W-1:0]    tenth_progress,
    input  logic [HOUR_W-1:0]     hour_tenths,
    input  logic [VSUM_W-1:0]     voltage_total,
    input  logic [SAMPLE_W-1:0]   current_average,
    input  logic                  power_off,
    input  logic                  sample_was_voltage,
    output int                    fail_count,
    output int                    pending_words
);

    typedef struct packed {
        tb_stat_t  timing;
        adc_stat_t adc;
    } meter_word_t;

    cfg_t                settings;
    logic [TICK_W-1:0]   tick_cnt;
    logic                blink_q;
    logic [TENTH_W-1:0]  tenth_cnt;
    logic [HOUR_W-1:0]   hour_cnt;
    logic                next_is_voltage;
    logic [SETTLE_W-1:0] settle_cnt;
    logic [VSUM_W-1:0]   volt_acc;
    logic [VCNT_W-1:0]   volt_cnt;
    logic [VSUM_W-1:0]   volt_total_q;
    logic [CSUM_W-1:0]   curr_acc;
    logic [CCNT_W-1:0]   curr_cnt;
    logic [SAMPLE_W-1:0] curr_avg_q;
    logic                power_off_q;
    meter_word_t         meter_words[$];

    // advance the meter by one tick and return the word it should show
    function automatic meter_word_t meter_tick(input logic [SAMPLE_W-1:0] sample);
        meter_word_t w;
        int          next_tick;
        int          next_tenth;
        logic        half_hit;
        logic        is_volt;
        next_tick = int'(tick_cnt) + 1;
        half_hit = (next_tick >= int'(settings.ticks_per_half_second));
        if (half_hit)
        begin
            tick_cnt = '0;
            blink_q = ~blink_q;
            next_tenth = int'(tenth_cnt) + 1;
            if (next_tenth >= int'(settings.half_seconds_per_tenth))
            begin
                tenth_cnt = '0;
                if (hour_cnt < settings.hour_limit)
                    hour_cnt = hour_cnt + 1'b1;
                else
                    hour_cnt = '0;
            end
            else
                tenth_cnt = next_tenth[TENTH_W-1:0];
        end
        else
            tick_cnt = next_tick[TICK_W-1:0];

        is_volt = next_is_voltage;
        next_is_voltage = ~next_is_voltage;

        if (is_volt)
        begin
            volt_acc = volt_acc + VSUM_W'(sample);
            // decision uses the settle count from before this tick
            if (sample < settings.low_voltage_level)
                power_off_q = (settle_cnt > settings.settle_limit);
            if (int'(volt_cnt) + 1 >= VOLT_SAMPLES)
            begin
                volt_total_q = volt_acc;
                volt_acc = '0;
                volt_cnt = '0;
            end
            else
                volt_cnt = volt_cnt + 1'b1;
        end
        else
        begin
            curr_acc = curr_acc + CSUM_W'(sample);
            if (int'(curr_cnt) + 1 >= CURR_SAMPLES)
            begin
                curr_avg_q = SAMPLE_W'(curr_acc >> CURR_SHIFT);
                curr_acc = '0;
                curr_cnt = '0;
            end
            else
                curr_cnt = curr_cnt + 1'b1;
        end

        if (half_hit && int'(settle_cnt) < SETTLE_MAX)
            settle_cnt = settle_cnt + 1'b1;

        w.timing.half_pulse = half_hit;
        w.timing.blink = blink_q;
        w.timing.tenth = tenth_cnt;
        w.timing.hour = hour_cnt;
        w.adc.voltage_total = volt_total_q;
        w.adc.current_average = curr_avg_q;
        w.adc.power_off = power_off_q;
        w.adc.was_voltage = is_volt;
        return w;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t mismatch %s: expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        meter_word_t want;
        if (!rst_n)
        begin
            settings.ticks_per_half_second = TICKS_RESET;
            settings.half_seconds_per_tenth = TENTHS_RESET;
            settings.hour_limit = HOUR_LIMIT_RESET;
            settings.low_voltage_level = LOW_LEVEL_RESET;
            settings.settle_limit = SETTLE_LIMIT_RESET;
            tick_cnt = '0;
            blink_q = 1'b0;
            tenth_cnt = '0;
            hour_cnt = '0;
            next_is_voltage = 1'b0;
            settle_cnt = '0;
            volt_acc = '0;
            volt_cnt = '0;
            volt_total_q = '0;
            curr_acc = '0;
            curr_cnt = '0;
            curr_avg_q = '0;
            power_off_q = 1'b0;
            meter_words.delete();
            fail_count = 0;
            pending_words = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_TICKS_PER_HALF: settings.ticks_per_half_second = cfg_data[TICK_W-1:0];
                    REG_HALF_PER_TENTH: settings.half_seconds_per_tenth = cfg_data[TENTH_W-1:0];
                    REG_HOUR_LIMIT:     settings.hour_limit = cfg_data[HOUR_W-1:0];
                    REG_LOW_LEVEL:      settings.low_voltage_level = cfg_data[SAMPLE_W-1:0];
                    REG_SETTLE_LIMIT:   settings.settle_limit = cfg_data[SETTLE_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (meter_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t output word with nothing expected", $time);
                end
                else
                begin
                    want = meter_words.pop_front();
                    check_field("half_second_pulse", want.timing.half_pulse, half_second_pulse);
                    check_field("blink", want.timing.blink, blink);
                    check_field("tenth_progress", want.timing.tenth, tenth_progress);
                    check_field("hour_tenths", want.timing.hour, hour_tenths);
                    check_field("voltage_total", want.adc.voltage_total, voltage_total);
                    check_field("current_average", want.adc.current_average, current_average);
                    check_field("power_off", want.adc.power_off, power_off);
                    check_field("sample_was_voltage", want.adc.was_voltage, sample_was_voltage);
                end
            end

            if (in_valid && in_ready)
                meter_words.push_back(meter_tick(adc_sample));
            pending_words = meter_words.size();
        end
    end

endmodule

@@ tb/tb_hour_meter_adc_averager.sv @@
`timescale 1ns / 1ps
// top of the hour meter adc averager testbench: clock, reset, register phases,
// sample stimulus with random gaps and output stalls, watchdog and verdict
// depends on hmaa_pkg, hour_meter_adc_averager and hmaa_meter_checker
module tb_hour_meter_adc_averager;
    import hmaa_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 72;
    localparam logic [SAMPLE_W-1:0] OPENING [24] = '{
        12'hFFF, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'd959, 12'hFFF, 12'd960,
        12'hFFF, 12'hAAA, 12'hFFF, 12'h555, 12'hFFF, 12'h001, 12'hFFF, 12'hFFE,
        12'h000, 12'h000, 12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'h000, 12'd959
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   adc_sample;
    logic                  out_valid;
    logic                  out_ready;
    logic                  half_second_pulse;
    logic                  blink;
    logic [TENTH_W-1:0]    tenth_progress;
    logic [HOUR_W-1:0]     hour_tenths;
    logic [VSUM_W-1:0]     voltage_total;
    logic [SAMPLE_W-1:0]   current_average;
    logic                  power_off;
    logic                  sample_was_voltage;

    int fail_count;
    int pending_words;
    int quiet_cycles;
    bit tx_quiet;
    bit rx_quiet;

    hour_meter_adc_averager dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .adc_sample         (adc_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .half_second_pulse  (half_second_pulse),
        .blink              (blink),
        .tenth_progress     (tenth_progress),
        .hour_tenths        (hour_tenths),
        .voltage_total      (voltage_total),
        .current_average    (current_average),
        .power_off          (power_off),
        .sample_was_voltage (sample_was_voltage)
    );

    hmaa_meter_checker meter_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .adc_sample         (adc_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .half_second_pulse  (half_second_pulse),
        .blink              (blink),
        .tenth_progress     (tenth_progress),
        .hour_tenths        (hour_tenths),
        .voltage_total      (voltage_total),
        .current_average    (current_average),
        .power_off          (power_off),
        .sample_was_voltage (sample_was_voltage),
        .fail_count         (fail_count),
        .pending_words      (pending_words)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random stall before taking each word
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = rx_quiet ? 0 : int'($urandom_range(0, 14));
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // offer one sample after a random gap, return at the negedge after acceptance
    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = tx_quiet ? 0 : int'($urandom_range(0, 14));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        adc_sample <= s;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        while (pending_words != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] reg_vals [5];
        logic [SAMPLE_W-1:0]   s;
        int                    level_now;
        int                    near;
        int                    phase;
        int                    k;
        bit                    all_high;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_TICKS_PER_HALF;
        cfg_data = '0;
        in_valid = 1'b0;
        adc_sample = '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: full-scale current words, voltage extremes and the low level edge
        foreach (OPENING[i])
            push_sample(OPENING[i]);
        drain_words();

        for (phase = 0; phase < PHASES; phase++)
        begin
            all_high = 1'b0;
            case (phase)
                0:
                begin
                    reg_vals = '{20'd1, 20'd1, 20'd3, 20'd2048, 20'd20};
                end
                1:
                begin
                    // zero registers: every tick a half second, every one a carry
                    reg_vals = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd0};
                end
                2:
                begin
                    // limit above the settle ceiling: low samples clear power-off again
                    reg_vals = '{20'd1, 20'd2, 20'd5, 20'd4095, 20'd127};
                end
                3:
                begin
                    reg_vals = '{20'd255, 20'd1023, 20'hFFFFF, 20'd4095, 20'd100};
                    all_high = 1'b1;
                end
                default:
                begin
                    reg_vals[REG_TICKS_PER_HALF] = CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                        $urandom_range(0, 255) : $urandom_range(0, 6));
                    reg_vals[REG_HALF_PER_TENTH] = CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                        $urandom_range(0, 1023) : $urandom_range(0, 4));
                    reg_vals[REG_HOUR_LIMIT] = CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                        $urandom_range(0, 20'hFFFFF) : $urandom_range(0, 9));
                    reg_vals[REG_LOW_LEVEL] = CFG_DATA_W'($urandom_range(0, 4095));
                    reg_vals[REG_SETTLE_LIMIT] = CFG_DATA_W'($urandom_range(0, 127));
                end
            endcase
            level_now = int'(reg_vals[REG_LOW_LEVEL]);

            for (k = 0; k < 5; k++)
            begin
                cfg_write <= 1'b1;
                cfg_index <= cfg_idx_t'(k);
                cfg_data <= reg_vals[k];
                @(negedge clk);
            end
            cfg_write <= 1'b0;

            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);

            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                case ($urandom_range(0, 7))
                    0: s = 12'h000;
                    1: s = 12'hFFF;
                    2, 3:
                    begin
                        // hover around the low voltage level
                        near = level_now + int'($urandom_range(0, 3)) - 2;
                        if (near < 0)
                            near = 0;
                        if (near > 4095)
                            near = 4095;
                        s = near[SAMPLE_W-1:0];
                    end
                    default: s = SAMPLE_W'($urandom_range(0, 4095));
                endcase
                if (all_high)
                    s = 12'hFFF;
                push_sample(s);
            end
            drain_words();
        end

        rx_quiet = 1'b0;
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
